@@ sv/slt_pkg.sv @@
// Shared types and codes for the sorted list table.
package slt_pkg;

  localparam int DATA_W = 32;
  localparam int FILL_W = 5;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic [1:0]               op_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [FILL_W-1:0]        fill_t;

  // One result item
  typedef struct packed {
    status_t status;
    data_t   entry;
    fill_t   fill;
    logic    last;
  } res_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

@@ sv/sorted_list_table.sv @@
// Sorted list table top level: sequencer, table memory, compare unit, result register.
// Insert walks down from the top of the stored entries, one entry at a time.
// Delete walks every stored entry; dump emits each stored entry in order.
// Full, empty and unused-op cases answer without a table walk. One item at a time; the
// compare unit and the single memory read port set the per-entry pace.
// Reset clears the count and control; table contents are undefined, no clearing pass.
module sorted_list_table #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  slt_pkg::op_t     in_op,
  input  slt_pkg::data_t   in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output slt_pkg::status_t out_status,
  output slt_pkg::data_t   out_entry,
  output slt_pkg::fill_t   out_fill,
  output logic             out_last
);
  import slt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_DEL_RD,
    S_DEL_CHK,
    S_DMP_RD,
    S_DMP_EMIT,
    S_RESP
  } state_t;

  state_t          state_r, state_nxt;
  data_t           val_r, val_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            found_r, found_nxt;
  status_t         stat_r, stat_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;

  logic [CW-1:0]   idx_m1;
  logic [CW-1:0]   idx_p1;
  logic            ofree;
  logic            accept;

  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  data_t           ram_wr_data;
  logic [AW-1:0]   ram_rd_addr;
  data_t           ram_rd_data;
  cmp_t            cmp;

  slt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  slt_cmp u_cmp (
    .a     (ram_rd_data),
    .b     (val_r),
    .flags (cmp)
  );

  assign idx_m1   = idx_r - CW'(1);
  assign idx_p1   = idx_r + CW'(1);
  assign ofree    = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sequencer next state, memory control and result loading
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r[AW-1:0];
    ram_wr_data   = val_r;
    ram_rd_addr   = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt   = in_value;
          found_nxt = 1'b0;
          stat_nxt  = ST_OK;
          unique case (in_op)
            OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            OP_DELETE: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DEL_RD;
              end
            end
            OP_DUMP: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DMP_RD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Insert: read the entry below the hole, or drop the value at the bottom
      S_INS_RD: begin
        ram_rd_addr = idx_m1[AW-1:0];
        if (idx_r == '0) begin
          ram_wr_en = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_INS_CHK;
        end
      end

      // Insert: smaller entry below stops the walk, otherwise move it up
      S_INS_CHK: begin
        ram_rd_addr = idx_m1[AW-1:0];
        ram_wr_en   = 1'b1;
        if (cmp.lt) begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          ram_wr_data = ram_rd_data;
          idx_nxt     = idx_m1;
          state_nxt   = S_INS_RD;
        end
      end

      S_DEL_RD: begin
        state_nxt = S_DEL_CHK;
      end

      // Delete: find the first match, then pull each later entry down by one
      S_DEL_CHK: begin
        ram_wr_addr = idx_m1[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_wr_en   = found_r;
        found_nxt   = found_r || cmp.eq;
        if (idx_p1 == count_r) begin
          if (found_r || cmp.eq) begin
            count_nxt = count_r - CW'(1);
          end else begin
            stat_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_DEL_RD;
        end
      end

      S_DMP_RD: begin
        state_nxt = S_DMP_EMIT;
      end

      // Dump: hand each entry to the result register when it is free
      S_DMP_EMIT: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          res_nxt.status = ST_OK;
          res_nxt.entry  = ram_rd_data;
          res_nxt.fill   = FILL_W'(count_r);
          res_nxt.last   = (idx_p1 == count_r);
          if (idx_p1 == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_DMP_RD;
          end
        end
      end

      // Single result for insert, delete, empty dump and unused op
      S_RESP: begin
        if (ofree) begin
          out_valid_nxt  = 1'b1;
          res_nxt.status = stat_r;
          res_nxt.entry  = '0;
          res_nxt.fill   = FILL_W'(count_r);
          res_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    stat_r  <= stat_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = res_r.status;
  assign out_entry  = res_r.entry;
  assign out_fill   = res_r.fill;
  assign out_last   = res_r.last;

endmodule

@@ sv/slt_ram.sv @@
// Table storage: one write port, one read port with registered read data.
module slt_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  slt_pkg::data_t    wr_data,
  input  logic [AW-1:0]     rd_addr,
  output slt_pkg::data_t    rd_data
);
  import slt_pkg::*;

  data_t mem [DEPTH];
  data_t rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/slt_cmp.sv @@
// Shared signed compare unit: less-than and equal of a stored value against the key.
module slt_cmp (
  input  slt_pkg::data_t a,
  input  slt_pkg::data_t b,
  output slt_pkg::cmp_t  flags
);
  import slt_pkg::*;

  always_comb begin
    flags.lt = (a < b);
    flags.eq = (a == b);
  end

endmodule
